// ----- rtl/tcpcw_pkg.sv -----
// shared types and constants of the tcp congestion window block
package tcpcw_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned MSS_W  = 16;
    localparam int unsigned DUP_W  = 2;

    localparam logic [MSS_W-1:0]  MSS_RESET      = 16'd1460;
    localparam logic [DATA_W-1:0] SSTHRESH_RESET = 32'd65535;
    localparam logic [DATA_W-1:0] CWND_RESET     = 32'(3 * int'(MSS_RESET));

    // duplicate acks that trigger fast retransmit
    localparam logic [DUP_W-1:0]  DUP_ACK_LIMIT  = 2'd3;

    localparam logic [DATA_W-1:0] CWND_MAX       = '1;

    // register indexes on the configuration port
    localparam logic REG_MSS      = 1'b0;
    localparam logic REG_SSTHRESH = 1'b1;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_ADV  = 2'd1,
        OP_CUT  = 2'd2
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [DUP_W-1:0]  dup_count;
        logic [DATA_W-1:0] peer_window;
    } job_t;

    typedef struct packed {
        logic              mss_we;
        logic              ssth_we;
        logic [MSS_W-1:0]  mss;
        logic [DATA_W-1:0] ssth;
    } cfg_wr_t;

endpackage

// ----- rtl/tcpcw_front.sv -----
// ack classifier: tracks highest ack and duplicate count, queues jobs
module tcpcw_front import tcpcw_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [DATA_W-1:0] s_ack_number,
    input  logic [DATA_W-1:0] s_peer_window,
    input  logic              q_full,
    output logic              push,
    output job_t              push_data
);

    logic [DATA_W-1:0] high_ack_reg, high_ack_next;
    logic [DUP_W-1:0]  dup_reg, dup_next;
    logic [DUP_W-1:0]  dup_inc;
    op_t               op;

    assign s_ready = ~q_full;
    assign push    = s_valid & s_ready;
    assign dup_inc = dup_reg + 2'd1;

    always_comb begin
        high_ack_next = high_ack_reg;
        dup_next      = dup_reg;
        op            = OP_NONE;
        if (s_ack_number == high_ack_reg) begin
            if (dup_inc >= DUP_ACK_LIMIT) begin
                op       = OP_CUT;
                dup_next = '0;
            end else begin
                dup_next = dup_inc;
            end
        end else if (s_ack_number > high_ack_reg) begin
            op            = OP_ADV;
            dup_next      = '0;
            high_ack_next = s_ack_number;
        end
    end

    assign push_data.op          = op;
    assign push_data.dup_count   = dup_next;
    assign push_data.peer_window = s_peer_window;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_ack_reg <= '0;
            dup_reg      <= '0;
        end else if (push) begin
            high_ack_reg <= high_ack_next;
            dup_reg      <= dup_next;
        end
    end

endmodule

// ----- rtl/tcpcw_queue.sv -----
// two-entry job queue between classifier and window engine
module tcpcw_queue import tcpcw_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_data,
    output logic full,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_data
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop       = pop_valid & pop_ready;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- rtl/tcpcw_back.sv -----
// window engine: cut, slow start, bit-serial avoidance divide, result register
module tcpcw_back import tcpcw_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [MSS_W-1:0]   mss_i,
    input  cfg_wr_t            cfg_i,
    input  logic               job_valid,
    output logic               job_ready,
    input  job_t               job_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [DATA_W-1:0]  m_cwnd_out,
    output logic [DATA_W-1:0]  m_ssthresh_out,
    output logic [DATA_W-1:0]  m_send_window,
    output logic [DUP_W-1:0]   m_dup_count_out,
    output logic               m_fast_retransmit
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_ADD   = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

    localparam int unsigned CNT_W = $clog2(DATA_W);

    state_t             state_reg, state_next;
    logic [DATA_W-1:0]  cwnd_reg, cwnd_next;
    logic [DATA_W-1:0]  ssth_reg, ssth_next;
    logic [DATA_W-1:0]  dvd_reg, dvd_next;
    logic [DATA_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DUP_W-1:0]   dup_reg, dup_next;
    logic [DATA_W-1:0]  pw_reg, pw_next;
    logic               cut_reg, cut_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_load;

    logic [DATA_W:0]    rem_shift;
    logic [DATA_W:0]    rem_diff;
    logic               q_bit;
    logic [DATA_W:0]    add_mss;
    logic [DATA_W:0]    add_quot;
    logic [DATA_W-1:0]  half;
    logic [DATA_W-1:0]  mss_ext;
    logic [DATA_W-1:0]  floor_ssth;

    assign mss_ext    = {{(DATA_W-MSS_W){1'b0}}, mss_i};
    assign half       = ssth_reg >> 1;
    assign floor_ssth = (half < mss_ext) ? mss_ext : half;
    assign add_mss    = {1'b0, cwnd_reg} + {1'b0, mss_ext};
    assign add_quot   = {1'b0, cwnd_reg} + {1'b0, dvd_reg};

    // restoring divide step, divisor is the window itself
    assign rem_shift  = {rem_reg, dvd_reg[DATA_W-1]};
    assign rem_diff   = rem_shift - {1'b0, cwnd_reg};
    assign q_bit      = (rem_shift >= {1'b0, cwnd_reg});

    assign job_ready  = (state_reg == ST_IDLE);
    assign out_load   = (state_reg == ST_WRITE) && (!out_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        cwnd_next  = cwnd_reg;
        ssth_next  = ssth_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        dup_next   = dup_reg;
        pw_next    = pw_reg;
        cut_next   = cut_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    dup_next   = job_data.dup_count;
                    pw_next    = job_data.peer_window;
                    cut_next   = (job_data.op == OP_CUT);
                    state_next = ST_WRITE;
                    case (job_data.op)
                        OP_CUT: begin
                            ssth_next = floor_ssth;
                            cwnd_next = floor_ssth;
                        end
                        OP_ADV: begin
                            if (cwnd_reg < ssth_reg || cwnd_reg == '0) begin
                                cwnd_next = add_mss[DATA_W] ? CWND_MAX
                                                            : add_mss[DATA_W-1:0];
                            end else begin
                                dvd_next   = DATA_W'(mss_i * mss_i);
                                rem_next   = '0;
                                cnt_next   = '0;
                                state_next = ST_DIV;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV: begin
                rem_next = q_bit ? rem_diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
                dvd_next = {dvd_reg[DATA_W-2:0], q_bit};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cwnd_next  = add_quot[DATA_W] ? CWND_MAX : add_quot[DATA_W-1:0];
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // register writes must come only while idle; the block itself does not enforce it
        if (cfg_i.mss_we) begin
            cwnd_next = ({{(DATA_W-MSS_W){1'b0}}, cfg_i.mss} << 1)
                      + {{(DATA_W-MSS_W){1'b0}}, cfg_i.mss};
        end
        if (cfg_i.ssth_we) begin
            ssth_next = cfg_i.ssth;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cwnd_reg      <= CWND_RESET;
            ssth_reg      <= SSTHRESH_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cwnd_reg      <= cwnd_next;
            ssth_reg      <= ssth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        dup_reg <= dup_next;
        pw_reg  <= pw_next;
        cut_reg <= cut_next;
        if (out_load) begin
            m_cwnd_out        <= cwnd_reg;
            m_ssthresh_out    <= ssth_reg;
            m_send_window     <= (cwnd_reg < pw_reg) ? cwnd_reg : pw_reg;
            m_dup_count_out   <= dup_reg;
            m_fast_retransmit <= cut_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

// ----- rtl/tcp_congestion_window.sv -----
// top level of the tcp reno congestion window tracker
// usage:
// - input channel s_*: one received ack per item (ack number, peer window)
// - result channel m_*: one result per ack with cwnd, ssthresh, send window,
//   duplicate count and the fast retransmit flag
// - apb port: mss at address 0, initial ssthresh at address 4; writing mss
//   reloads cwnd with 3*mss, writing initial ssthresh reloads ssthresh
// - a classifier takes acks, tracks the highest ack and duplicates, and
//   pushes jobs into a two-entry queue; the window engine drains it
// - path: a cut, duplicate, lower or slow start ack goes through the queue,
//   the engine's idle and write states and the result register; a congestion
//   avoidance ack also passes the divide setup, the 32-step bit-serial
//   divide of mss*mss by cwnd and its saturating add; the engine takes
//   the next job only once the last result is loaded into the result register
// - the classifier keeps taking acks until the queue fills, so a stalled
//   result side backs up into s_ready only after two queued items
// - reset: cwnd = 3*1460, ssthresh = 65535, highest ack and duplicate
//   count zero, queue and result register empty
module tcp_congestion_window import tcpcw_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // ack input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [DATA_W-1:0]  s_ack_number,
    input  logic [DATA_W-1:0]  s_peer_window,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [DATA_W-1:0]  m_cwnd_out,
    output logic [DATA_W-1:0]  m_ssthresh_out,
    output logic [DATA_W-1:0]  m_send_window,
    output logic [DUP_W-1:0]   m_dup_count_out,
    output logic               m_fast_retransmit,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [MSS_W-1:0]  mss_reg;
    logic [DATA_W-1:0] init_ssth_reg;
    logic              cfg_we;
    cfg_wr_t           cfg;

    logic              q_full;
    logic              push;
    job_t              push_data;
    logic              job_valid;
    logic              job_ready;
    job_t              job_data;

    // apb: always ready, register picked by address bit 2
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;

    assign cfg.mss_we  = cfg_we && (paddr[2] == REG_MSS);
    assign cfg.ssth_we = cfg_we && (paddr[2] == REG_SSTHRESH);
    assign cfg.mss     = pwdata[MSS_W-1:0];
    assign cfg.ssth    = pwdata;

    assign prdata = (paddr[2] == REG_MSS) ? {{(32-MSS_W){1'b0}}, mss_reg}
                                          : init_ssth_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mss_reg       <= MSS_RESET;
            init_ssth_reg <= SSTHRESH_RESET;
        end else begin
            if (cfg.mss_we) begin
                mss_reg <= cfg.mss;
            end
            if (cfg.ssth_we) begin
                init_ssth_reg <= cfg.ssth;
            end
        end
    end

    // front: classify acks
    tcpcw_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_ack_number  (s_ack_number),
        .s_peer_window (s_peer_window),
        .q_full        (q_full),
        .push          (push),
        .push_data     (push_data)
    );

    // queue between classifier and engine
    tcpcw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop_valid (job_valid),
        .pop_ready (job_ready),
        .pop_data  (job_data)
    );

    // back: window arithmetic and result register
    tcpcw_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .mss_i             (mss_reg),
        .cfg_i             (cfg),
        .job_valid         (job_valid),
        .job_ready         (job_ready),
        .job_data          (job_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cwnd_out        (m_cwnd_out),
        .m_ssthresh_out    (m_ssthresh_out),
        .m_send_window     (m_send_window),
        .m_dup_count_out   (m_dup_count_out),
        .m_fast_retransmit (m_fast_retransmit)
    );

    // a cut sets cwnd to the new ssthresh and clears the duplicate count
    a_cut_window: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fast_retransmit |->
            (m_cwnd_out == m_ssthresh_out) && (m_dup_count_out == '0))
        else $error("fast retransmit result inconsistent");

    // send window never exceeds the congestion window
    a_send_window: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_send_window <= m_cwnd_out)
        else $error("send window above cwnd");

    // duplicate count stays below the limit
    a_dup_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_dup_count_out < DUP_ACK_LIMIT)
        else $error("duplicate count out of range");

    // once the engine takes a job it leaves idle
    a_queue_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        job_ready && job_valid |=> !job_ready)
        else $error("engine did not leave idle after taking a job");

endmodule

// ----- tb/tcpcw_window_check.sv -----
// checker for the tcp congestion window tracker: tracks window state and compares every result
module tcpcw_window_check
    import tcpcw_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [DATA_W-1:0]  s_ack_number,
    input  logic [DATA_W-1:0]  s_peer_window,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [DATA_W-1:0]  m_cwnd_out,
    input  logic [DATA_W-1:0]  m_ssthresh_out,
    input  logic [DATA_W-1:0]  m_send_window,
    input  logic [DUP_W-1:0]   m_dup_count_out,
    input  logic               m_fast_retransmit,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 errors,
    output int                 results_done
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_MSS      = {REG_MSS, 2'b00};
    localparam logic [2:0] ADDR_SSTHRESH = {REG_SSTHRESH, 2'b00};

    typedef struct packed {
        logic [DATA_W-1:0] cwnd;
        logic [DATA_W-1:0] ssthresh;
        logic [DATA_W-1:0] send_win;
        logic [DUP_W-1:0]  dups;
        logic              retransmit;
    } window_result_t;

    window_result_t    window_q[$];

    logic [MSS_W-1:0]  mss_reg;
    logic [DATA_W-1:0] cwnd;
    logic [DATA_W-1:0] ssthresh;
    logic [DATA_W-1:0] top_ack;
    logic [DATA_W-1:0] peer_win;
    logic [DUP_W-1:0]  dup_acks;

    // one ack against the tracked window state
    function automatic window_result_t track_ack(input logic [DATA_W-1:0] ack,
                                                 input logic [DATA_W-1:0] pw);
        op_t               op;
        logic [63:0]       grown;
        logic [DATA_W-1:0] half;
        logic [DATA_W-1:0] floor_mss;
        window_result_t    r;
        op = OP_NONE;
        floor_mss = DATA_W'(mss_reg);
        peer_win = pw;
        if (ack == top_ack) begin
            dup_acks = dup_acks + 1'b1;
            if (dup_acks >= DUP_ACK_LIMIT) begin
                half = ssthresh >> 1;
                ssthresh = (half < floor_mss) ? floor_mss : half;
                cwnd = ssthresh;
                dup_acks = '0;
                op = OP_CUT;
            end
        end else if (ack > top_ack) begin
            dup_acks = '0;
            top_ack = ack;
            op = OP_ADV;
            // slow start, or a zero window that cannot be divided by
            if (cwnd < ssthresh || cwnd == '0) begin
                grown = 64'(cwnd) + 64'(mss_reg);
            end else begin
                grown = 64'(cwnd) + (64'(mss_reg) * 64'(mss_reg)) / 64'(cwnd);
            end
            cwnd = (grown > 64'(CWND_MAX)) ? CWND_MAX : grown[DATA_W-1:0];
        end
        r.cwnd       = cwnd;
        r.ssthresh   = ssthresh;
        r.send_win   = (cwnd < peer_win) ? cwnd : peer_win;
        r.dups       = dup_acks;
        r.retransmit = (op == OP_CUT);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : watch
        window_result_t want;
        if (!aresetn) begin
            mss_reg  = MSS_RESET;
            cwnd     = CWND_RESET;
            ssthresh = SSTHRESH_RESET;
            top_ack  = '0;
            dup_acks = '0;
            peer_win = '0;
            window_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_MSS) begin
                    mss_reg = pwdata[MSS_W-1:0];
                    cwnd = DATA_W'(mss_reg) * 3;
                end else if (paddr == ADDR_SSTHRESH) begin
                    ssthresh = pwdata;
                end
            end
            if (m_valid && m_ready) begin
                results_done <= results_done + 1;
                if (window_q.size() == 0) begin
                    $display("%0t ns: result with nothing expected, expected none actual cwnd %h",
                             $time, m_cwnd_out);
                    errors++;
                end else begin
                    want = window_q.pop_front();
                    check_field("cwnd_out", want.cwnd, m_cwnd_out);
                    check_field("ssthresh_out", want.ssthresh, m_ssthresh_out);
                    check_field("send_window", want.send_win, m_send_window);
                    check_field("dup_count_out", DATA_W'(want.dups), DATA_W'(m_dup_count_out));
                    check_field("fast_retransmit", DATA_W'(want.retransmit),
                                DATA_W'(m_fast_retransmit));
                end
            end
            if (s_valid && s_ready) begin
                window_q.insert(window_q.size(), track_ack(s_ack_number, s_peer_window));
            end
        end
    end

endmodule

// ----- tb/tb_tcp_congestion_window.sv -----
// testbench top for the tcp congestion window tracker: stimulus, pacing and verdict
module tb_tcp_congestion_window;
    timeunit 1ns;
    timeprecision 1ps;
    import tcpcw_pkg::*;

    // generous bound, far above the slowest legal run
    localparam int CYCLE_LIMIT  = 1_500_000;
    // advancing slow start acks from a halved max window
    localparam int SAT_ACKS     = 60;
    // receiver hold-off: starts after this many results, lasts this long
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 250;
    // settle time after the last result, above the avoidance latency
    localparam int DRAIN_CYCLES = 60;

    localparam logic [2:0] ADDR_MSS      = {REG_MSS, 2'b00};
    localparam logic [2:0] ADDR_SSTHRESH = {REG_SSTHRESH, 2'b00};

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [DATA_W-1:0] s_ack_number;
    logic [DATA_W-1:0] s_peer_window;
    logic              m_valid;
    logic              m_ready;
    logic [DATA_W-1:0] m_cwnd_out;
    logic [DATA_W-1:0] m_ssthresh_out;
    logic [DATA_W-1:0] m_send_window;
    logic [DUP_W-1:0]  m_dup_count_out;
    logic              m_fast_retransmit;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // pacing and bookkeeping on the stimulus side
    logic              calm = 1'b0;       // no idling on either side while set
    int                items_sent = 0;    // acks accepted by the block
    logic [31:0]       ack_mark = '0;     // highest ack offered so far
    int                fail_count;
    int                results_done;

    tcp_congestion_window uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_ack_number      (s_ack_number),
        .s_peer_window     (s_peer_window),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cwnd_out        (m_cwnd_out),
        .m_ssthresh_out    (m_ssthresh_out),
        .m_send_window     (m_send_window),
        .m_dup_count_out   (m_dup_count_out),
        .m_fast_retransmit (m_fast_retransmit),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    tcpcw_window_check window_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_ack_number      (s_ack_number),
        .s_peer_window     (s_peer_window),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cwnd_out        (m_cwnd_out),
        .m_ssthresh_out    (m_ssthresh_out),
        .m_send_window     (m_send_window),
        .m_dup_count_out   (m_dup_count_out),
        .m_fast_retransmit (m_fast_retransmit),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .pready            (pready),
        .errors            (fail_count),
        .results_done      (results_done)
    );

    // 50 MHz clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // run limit: a hung handshake ends here
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // result side: random back-pressure, one long hold-off so the queue
    // fills and s_ready drops while acks keep coming
    initial begin : result_side
        int   seen;
        int   hold;
        logic held;
        seen = 0;
        hold = 0;
        held = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) seen++;
            if (seen == HOLD_AT && !held) begin
                hold = HOLD_CYCLES;
                held = 1'b1;
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else if (calm) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 20);
            end
        end
    end

    // peer windows: zero, all ones, near typical cwnd values, or anything
    function automatic logic [31:0] rand_window();
        case ($urandom_range(0, 9))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2, 3, 4, 5: begin
                return $urandom_range(0, 300000);
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    // offer one ack; valid stays up between back-to-back items
    task automatic offer_ack(input logic [31:0] ack, input logic [31:0] pw);
        if (!calm && $urandom_range(0, 99) < 20) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_ack_number  <= ack;
        s_peer_window <= pw;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (ack > ack_mark) ack_mark = ack;
    endtask

    // sender pauses until every accepted ack has its result
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_done != items_sent);
    endtask

    // apb write: setup phase, access phase, then back to idle
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // new setting, written only once the block has gone idle
    task automatic configure(input logic [31:0] mss_word, input logic [31:0] ssth_word);
        drain();
        write_reg(ADDR_MSS, mss_word);
        write_reg(ADDR_SSTHRESH, ssth_word);
    endtask

    // mostly well-formed ack streams: advances, triple duplicates that
    // trigger fast retransmit, stray duplicates and stale acks
    task automatic run_traffic(input int count);
        int sent;
        int pick;
        int k;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                if ($urandom_range(0, 19) == 0) begin
                    offer_ack(ack_mark + $urandom_range(1, 1 << 20), rand_window());
                end else begin
                    offer_ack(ack_mark + $urandom_range(1, 3000), rand_window());
                end
                sent++;
            end else if (pick < 75) begin
                for (k = 0; k < 3; k++) offer_ack(ack_mark, rand_window());
                sent += 3;
            end else if (pick < 85) begin
                offer_ack(ack_mark, rand_window());
                sent++;
            end else begin
                offer_ack($urandom_range(0, ack_mark), rand_window());
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        int k;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_ack_number  <= '0;
        s_peer_window <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, on reset settings
        // highest ack starts at zero, so a zero ack is already a duplicate
        offer_ack(32'd0, 32'h0000_0000);
        offer_ack(32'd0, 32'hFFFF_FFFF);
        // slow start growth, then a stale ack
        offer_ack(32'd1460, 32'd1000);
        offer_ack(32'd700, 32'd5000);
        // three duplicates cut the window
        offer_ack(32'd1460, 32'd9000);
        offer_ack(32'd1460, 32'd9000);
        offer_ack(32'd1460, 32'd100);
        // window now equals threshold: congestion avoidance
        offer_ack(32'd2920, 32'hFFFF_FFFF);
        offer_ack(32'd2920, 32'd40000);
        offer_ack(32'd4380, 32'h8000_0000);
        offer_ack(32'd4380, 32'd0);
        offer_ack(32'd4380, 32'd100);
        offer_ack(32'd4380, 32'h7FFF_FFFF);
        offer_ack(32'd5840, 32'h5555_5555);

        // random phases over several settings
        configure(32'd536, 32'd8000);
        run_traffic(350);
        // largest segment and threshold, no idling anywhere
        calm = 1'b1;
        configure(32'd65535, 32'hFFFF_FFFF);
        run_traffic(250);
        calm = 1'b0;
        // smallest legal settings: avoidance growth rounds to nothing
        configure(32'd1, 32'd1);
        run_traffic(250);
        // zero segment and zero threshold: window stuck at zero
        configure(32'd0, 32'd0);
        run_traffic(100);
        // upper bits of the mss word are not part of the register
        configure(32'hDEAD_05B4, $urandom_range(1000, 200000));
        run_traffic(300);

        // large windows: cut from the max threshold, raise the threshold
        // again, then slow start upward from half the top
        configure(32'd65535, 32'hFFFF_FFFF);
        offer_ack(ack_mark + 1, rand_window());
        for (k = 0; k < 3; k++) offer_ack(ack_mark, rand_window());
        drain();
        write_reg(ADDR_SSTHRESH, 32'hFFFF_FFFF);
        calm = 1'b1;
        for (k = 0; k < SAT_ACKS; k++) offer_ack(ack_mark + 1, rand_window());
        calm = 1'b0;

        // top of the ack range, then stale acks across all bits
        offer_ack(32'hFFFF_FF00, rand_window());
        offer_ack(32'hFFFF_FFFF, rand_window());
        for (k = 0; k < 3; k++) offer_ack(32'hFFFF_FFFF, rand_window());
        for (k = 0; k < 12; k++) offer_ack($urandom, rand_window());

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/tcpcw_pkg.sv
rtl/tcpcw_front.sv
rtl/tcpcw_queue.sv
rtl/tcpcw_back.sv
rtl/tcp_congestion_window.sv
tb/tcpcw_window_check.sv
tb/tb_tcp_congestion_window.sv
